>>> rtl/mbe_pkg.sv
package mbe_pkg;

  localparam int COORD_BITS  = 12;
  localparam int REG_BITS    = 32;
  localparam int LIMIT_BITS  = 17;
  localparam int COLOR_BITS  = 28;
  localparam int COLOR_SHIFT = 20;
  localparam int COLOR_KEEP  = 8;
  localparam int INDEX_BITS  = 3;

  localparam int DEF_WORD_BITS = 32;
  localparam int DEF_FRAC_BITS = 28;

  localparam logic [REG_BITS-1:0]   RESET_REAL_ORIGIN = 32'hE000_0000;
  localparam logic [REG_BITS-1:0]   RESET_IMAG_ORIGIN = 32'hE000_0000;
  localparam logic [REG_BITS-1:0]   RESET_REAL_STEP   = 32'h0010_0000;
  localparam logic [REG_BITS-1:0]   RESET_IMAG_STEP   = 32'h0010_0000;
  localparam logic [LIMIT_BITS-1:0] RESET_LIMIT       = 17'd100000;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_REAL_ORIGIN = 3'd0,
    REG_IMAG_ORIGIN = 3'd1,
    REG_REAL_STEP   = 3'd2,
    REG_IMAG_STEP   = 3'd3,
    REG_ITER_LIMIT  = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [REG_BITS-1:0]   real_origin;
    logic [REG_BITS-1:0]   imag_origin;
    logic [REG_BITS-1:0]   real_step;
    logic [REG_BITS-1:0]   imag_step;
    logic [LIMIT_BITS-1:0] iteration_limit;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_row;
    logic [COORD_BITS-1:0] pixel_col;
  } pixel_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] out_row;
    logic [COORD_BITS-1:0] out_col;
    logic [LIMIT_BITS-1:0] iterations;
    logic [COLOR_BITS-1:0] color_word;
  } result_t;

endpackage

>>> rtl/mbe_front.sv
module mbe_front import mbe_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int JOB_BITS  = 2 * COORD_BITS + 2 * DEF_WORD_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                pixel_valid,
  output logic                pixel_stall,
  input  pixel_t              pixel,
  output logic                push,
  input  logic                q_full,
  output logic [JOB_BITS-1:0] push_data
);

  localparam int PROD_W = COORD_BITS + 1 + REG_BITS;
  localparam int CW     = (PROD_W + 1 > WORD_BITS + 1) ? PROD_W + 1 : WORD_BITS + 1;
  localparam logic [WORD_BITS-1:0] MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] MINV = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic                     stage_valid;
  logic [COORD_BITS-1:0]    stage_row;
  logic [COORD_BITS-1:0]    stage_col;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_i;
  logic signed [CW-1:0]     sum_r;
  logic signed [CW-1:0]     sum_i;
  logic [WORD_BITS-1:0]     c_r;
  logic [WORD_BITS-1:0]     c_i;
  logic                     accept;

  function automatic logic [WORD_BITS-1:0] sat_word(input logic signed [CW-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[CW-1:WORD_BITS-1];
    hi_zeros = ~|v[CW-1:WORD_BITS-1];
    if (hi_ones || hi_zeros) begin
      return v[WORD_BITS-1:0];
    end else if (v[CW-1]) begin
      return MINV;
    end else begin
      return MAXV;
    end
  endfunction

  assign pixel_stall = stage_valid && q_full;
  assign accept      = pixel_valid && !pixel_stall;
  assign push        = stage_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_row <= pixel.pixel_row;
      stage_col <= pixel.pixel_col;
      prod_r    <= $signed({1'b0, pixel.pixel_col}) * $signed(cfg.real_step);
      prod_i    <= $signed({1'b0, pixel.pixel_row}) * $signed(cfg.imag_step);
    end
  end

  // origin plus index times step, clamped to the working word
  assign sum_r = CW'($signed(cfg.real_origin)) + CW'(prod_r);
  assign sum_i = CW'($signed(cfg.imag_origin)) + CW'(prod_i);
  assign c_r   = sat_word(sum_r);
  assign c_i   = sat_word(sum_i);

  assign push_data = {stage_row, stage_col, c_r, c_i};

endmodule

>>> rtl/mbe_queue.sv
module mbe_queue #(
  parameter int WIDTH = 88
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/mbe_back.sv
module mbe_back import mbe_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int JOB_BITS  = 2 * COORD_BITS + 2 * DEF_WORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [LIMIT_BITS-1:0] iteration_limit,
  input  logic                  q_empty,
  output logic                  pop,
  input  logic [JOB_BITS-1:0]   pop_data,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result
);

  localparam int PW  = 2 * WORD_BITS;
  localparam int DW  = PW + 1;
  localparam int RW  = PW + 2;
  localparam logic [DW-1:0] FOUR = DW'(1) << (2 * FRAC_BITS + 2);
  localparam logic [WORD_BITS-1:0] MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] MINV = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t                      state;
  logic [COORD_BITS-1:0]       row;
  logic [COORD_BITS-1:0]       col;
  logic signed [WORD_BITS-1:0] cr;
  logic signed [WORD_BITS-1:0] ci;
  logic signed [WORD_BITS-1:0] zr;
  logic signed [WORD_BITS-1:0] zi;
  logic signed [PW-1:0]        rr;
  logic signed [PW-1:0]        ii;
  logic signed [PW-1:0]        ri;
  logic [LIMIT_BITS-1:0]       n;

  logic [DW-1:0]               mag_sum;
  logic                        escape;
  logic                        done;
  logic signed [DW-1:0]        diff;
  logic signed [DW-1:0]        diff_sh;
  logic signed [RW-1:0]        re_wide;
  logic signed [PW-1:0]        ri_sh;
  logic signed [DW-1:0]        im_wide;
  logic [WORD_BITS-1:0]        zr_next;
  logic [WORD_BITS-1:0]        zi_next;
  logic                        out_free;
  logic                        finish;

  function automatic logic [WORD_BITS-1:0] sat_re(input logic signed [RW-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[RW-1:WORD_BITS-1];
    hi_zeros = ~|v[RW-1:WORD_BITS-1];
    if (hi_ones || hi_zeros) begin
      return v[WORD_BITS-1:0];
    end else if (v[RW-1]) begin
      return MINV;
    end else begin
      return MAXV;
    end
  endfunction

  function automatic logic [WORD_BITS-1:0] sat_im(input logic signed [DW-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[DW-1:WORD_BITS-1];
    hi_zeros = ~|v[DW-1:WORD_BITS-1];
    if (hi_ones || hi_zeros) begin
      return v[WORD_BITS-1:0];
    end else if (v[DW-1]) begin
      return MINV;
    end else begin
      return MAXV;
    end
  endfunction

  // squares are never negative, so the magnitude sum is an unsigned add
  assign mag_sum = {1'b0, rr} + {1'b0, ii};
  assign escape  = (mag_sum >= FOUR);
  assign done    = (n >= iteration_limit) || escape;

  assign diff    = DW'(rr) - DW'(ii);
  assign diff_sh = diff >>> FRAC_BITS;
  assign re_wide = RW'(diff_sh) + RW'(cr);
  assign ri_sh   = ri >>> (FRAC_BITS - 1);
  assign im_wide = DW'(ri_sh) + DW'(ci);
  assign zr_next = sat_re(re_wide);
  assign zi_next = sat_im(im_wide);

  assign out_free = !result_valid || !result_stall;
  assign finish   = ((state == ST_UPD) && done || (state == ST_FIN)) && out_free;
  assign pop      = (state == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (!done) begin
            state <= ST_MUL;
          end else if (out_free) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      {row, col, cr, ci} <= pop_data;
      zr <= '0;
      zi <= '0;
      n  <= '0;
    end
    if (state == ST_MUL) begin
      rr <= zr * zr;
      ii <= zi * zi;
      ri <= zr * zi;
    end
    if ((state == ST_UPD) && !done) begin
      zr <= zr_next;
      zi <= zi_next;
      n  <= n + LIMIT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.out_row    <= row;
      result.out_col    <= col;
      result.iterations <= n;
      result.color_word <= {n[COLOR_KEEP-1:0], {COLOR_SHIFT{1'b0}}};
    end
  end

endmodule

>>> rtl/mandelbrot_escape_time_pixel.sv
// Mandelbrot escape-time engine, one pixel word in, one result word out.
// Pixel channel: pixel_valid / pixel_stall carry a row and column word.
// Result channel: result_valid / result_stall carry the coordinates, the
// iteration count and the color word (count mod 256, shifted left by 20).
// Configuration: cfg_we writes cfg_data into register cfg_index (origins,
// steps, iteration limit); write only while no pixel is in flight.
// A front stage maps the pixel to c and drops it into a two-entry queue;
// the back end iterates z = z*z + c, each iteration a square step
// and then an update and escape test, one pixel at a time.
// Back to back pixels are paced by the iteration loop of the back end.
// The front accepts up to three words ahead.
// Reset (rst, synchronous) empties the queue, drops any result and loads
// the register defaults. A stalled result holds in the output register;
// the back end then waits, the queue fills and pixel_stall rises.
module mandelbrot_escape_time_pixel import mbe_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  pixel_t                pixel,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [INDEX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]   cfg_data
);

  localparam int JOB_BITS = 2 * COORD_BITS + 2 * WORD_BITS;

  cfg_t                cfg;
  logic                push;
  logic                q_full;
  logic [JOB_BITS-1:0] push_data;
  logic                pop;
  logic                q_empty;
  logic [JOB_BITS-1:0] pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.real_origin     <= RESET_REAL_ORIGIN;
      cfg.imag_origin     <= RESET_IMAG_ORIGIN;
      cfg.real_step       <= RESET_REAL_STEP;
      cfg.imag_step       <= RESET_IMAG_STEP;
      cfg.iteration_limit <= RESET_LIMIT;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_REAL_ORIGIN: cfg.real_origin     <= cfg_data;
        REG_IMAG_ORIGIN: cfg.imag_origin     <= cfg_data;
        REG_REAL_STEP:   cfg.real_step       <= cfg_data;
        REG_IMAG_STEP:   cfg.imag_step       <= cfg_data;
        REG_ITER_LIMIT:  cfg.iteration_limit <= cfg_data[LIMIT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  mbe_front #(
    .WORD_BITS (WORD_BITS),
    .JOB_BITS  (JOB_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .push        (push),
    .q_full      (q_full),
    .push_data   (push_data)
  );

  mbe_queue #(
    .WIDTH (JOB_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_data  (pop_data)
  );

  mbe_back #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .JOB_BITS  (JOB_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .iteration_limit (cfg.iteration_limit),
    .q_empty         (q_empty),
    .pop             (pop),
    .pop_data        (pop_data),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result          (result)
  );

endmodule
